>>> hw/rtl/a1p_pkg.sv
// Shared constants, types and status codes for the A1 cell reference parser.
`default_nettype none

package a1p_pkg;

   // Field widths of the result.
   localparam int COL_BITS = 24;
   localparam int ROW_BITS = 31;
   localparam int CHAR_W   = 8;
   localparam int STATUS_W = 3;
   localparam int LETTER_W = 5;
   localparam int DIGIT_W  = 4;

   // Accumulator widths: one bit above the field so the saturation marks fit.
   localparam int COL_ACC_W = COL_BITS + 1;
   localparam int ROW_ACC_W = ROW_BITS + 1;

   // Saturation limits of the accumulators.
   localparam logic [COL_ACC_W-1:0] COL_LIMIT = COL_ACC_W'(1) << COL_BITS;
   localparam logic [ROW_ACC_W-1:0] ROW_LIMIT = ROW_ACC_W'(1) << ROW_BITS;

   // Radix of the column and row numbers.
   localparam int COL_RADIX = 26;
   localparam int ROW_RADIX = 10;

   // Result status codes.
   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 3'd0,
      ST_NO_COL    = 3'd1,
      ST_NO_ROW    = 3'd2,
      ST_NO_DIGITS = 3'd3,
      ST_TRAILING  = 3'd4,
      ST_BELOW_ONE = 3'd5,
      ST_RANGE     = 3'd6
   } status_type;

   // Classification of one character.
   typedef struct packed {
      logic                is_letter;
      logic [LETTER_W-1:0] letter_val;
      logic                is_space;
      logic                is_plus;
      logic                is_minus;
      logic                is_digit;
      logic [DIGIT_W-1:0]  digit_val;
   } char_class_type;

   // One finished result.
   typedef struct packed {
      status_type          status;
      logic [ROW_BITS-1:0] row_index;
      logic [COL_BITS-1:0] col_index;
   } result_type;

endpackage

`default_nettype wire

>>> hw/rtl/a1p_if.sv
// Valid/ready channel interfaces for parser requests and results.
`default_nettype none

interface a1p_req_if import a1p_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [CHAR_W-1:0] character;
   logic              last;

   modport source (output valid, output character, output last, input ready);
   modport sink (input valid, input character, input last, output ready);
endinterface

interface a1p_rsp_if import a1p_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [ROW_BITS-1:0] row_index;
   logic [COL_BITS-1:0] col_index;

   modport source (output valid, output status, output row_index, output col_index,
                   input ready);
   modport sink (input valid, input status, input row_index, input col_index,
                 output ready);
endinterface

`default_nettype wire

>>> hw/rtl/a1p_char_class.sv
// Character classifier: letters, digits, signs and whitespace of one byte.
`default_nettype none

module a1p_char_class import a1p_pkg::*; (
   input  wire logic [CHAR_W-1:0] character,
   output char_class_type         char_class
);

   localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'h41;
   localparam logic [CHAR_W-1:0] CHAR_UPPER_Z = 8'h5A;
   localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 8'h61;
   localparam logic [CHAR_W-1:0] CHAR_LOWER_Z = 8'h7A;
   localparam logic [CHAR_W-1:0] CHAR_ZERO    = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_NINE    = 8'h39;
   localparam logic [CHAR_W-1:0] CHAR_PLUS    = 8'h2B;
   localparam logic [CHAR_W-1:0] CHAR_MINUS   = 8'h2D;
   localparam logic [CHAR_W-1:0] CHAR_BLANK   = 8'h20;
   localparam logic [CHAR_W-1:0] CHAR_TAB     = 8'h09;
   localparam logic [CHAR_W-1:0] CHAR_CR      = 8'h0D;

   logic is_upper;
   logic is_lower;

   // Letters of either case map to 1..26.
   assign is_upper = (character >= CHAR_UPPER_A) && (character <= CHAR_UPPER_Z);
   assign is_lower = (character >= CHAR_LOWER_A) && (character <= CHAR_LOWER_Z);

   always_comb begin
      char_class.is_letter  = is_upper || is_lower;
      char_class.letter_val = '0;
      if (is_upper) begin
         char_class.letter_val = LETTER_W'(character - CHAR_UPPER_A + 8'd1);
      end else if (is_lower) begin
         char_class.letter_val = LETTER_W'(character - CHAR_LOWER_A + 8'd1);
      end
      // Whitespace is the blank and the control codes TAB through CR.
      char_class.is_space  = (character == CHAR_BLANK) ||
                             ((character >= CHAR_TAB) && (character <= CHAR_CR));
      char_class.is_plus   = (character == CHAR_PLUS);
      char_class.is_minus  = (character == CHAR_MINUS);
      char_class.is_digit  = (character >= CHAR_ZERO) && (character <= CHAR_NINE);
      char_class.digit_val = DIGIT_W'(character - CHAR_ZERO);
   end

endmodule

`default_nettype wire

>>> hw/rtl/a1p_parser.sv
// Parser state: column and row accumulators, phase tracking and result decode.
`default_nettype none

module a1p_parser import a1p_pkg::*; (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           step,
   input  wire logic           last,
   input  wire char_class_type char_class,
   output result_type          result
);

   localparam int COL_PROD_W = COL_BITS + 6;
   localparam int ROW_PROD_W = ROW_BITS + 5;

   typedef enum logic [2:0] {
      PH_START,
      PH_COL,
      PH_SPACE,
      PH_SIGNED,
      PH_DIGITS,
      PH_ERROR
   } phase_type;

   phase_type              phase_ff, phase_in;
   logic [COL_ACC_W-1:0]   col_acc_ff, col_acc_in;
   logic [ROW_ACC_W-1:0]   row_acc_ff, row_acc_in;
   logic                   row_neg_ff, row_neg_in;
   logic                   overflow_ff, overflow_in;
   status_type             error_ff, error_in;

   logic [COL_PROD_W-1:0]  col_next;
   logic [COL_ACC_W-1:0]   col_added;
   logic [ROW_PROD_W-1:0]  row_next;
   logic [ROW_ACC_W-1:0]   row_added;
   logic                   row_over;
   logic                   range_now;
   logic                   range_fin;

   // Column accumulation in bijective base 26, saturating one above the limit.
   assign col_next = COL_PROD_W'(col_acc_ff) * COL_PROD_W'(COL_RADIX)
                   + COL_PROD_W'(char_class.letter_val);
   always_comb begin
      if (col_acc_ff > COL_LIMIT) begin
         col_added = col_acc_ff;
      end else if (col_next > COL_PROD_W'(COL_LIMIT)) begin
         col_added = COL_LIMIT + COL_ACC_W'(1);
      end else begin
         col_added = COL_ACC_W'(col_next);
      end
   end

   // Row accumulation in decimal, saturating at the limit with a sticky flag.
   assign row_next = ROW_PROD_W'(row_acc_ff) * ROW_PROD_W'(ROW_RADIX)
                   + ROW_PROD_W'(char_class.digit_val);
   assign row_over = !overflow_ff && (row_next > ROW_PROD_W'(ROW_LIMIT));
   always_comb begin
      if (overflow_ff) begin
         row_added = row_acc_ff;
      end else if (row_over) begin
         row_added = ROW_LIMIT;
      end else begin
         row_added = ROW_ACC_W'(row_next);
      end
   end

   // Range check on the current row, used when trailing characters appear.
   assign range_now = overflow_ff || (!row_neg_ff && (row_acc_ff > ROW_LIMIT - ROW_ACC_W'(1)));

   // Next state for the current character.
   always_comb begin
      phase_in    = phase_ff;
      col_acc_in  = col_acc_ff;
      row_acc_in  = row_acc_ff;
      row_neg_in  = row_neg_ff;
      overflow_in = overflow_ff;
      error_in    = error_ff;
      unique case (phase_ff)
         PH_START: begin
            if (char_class.is_letter) begin
               col_acc_in = col_added;
               phase_in   = PH_COL;
            end else begin
               error_in = ST_NO_COL;
               phase_in = PH_ERROR;
            end
         end
         PH_COL, PH_SPACE: begin
            if ((phase_ff == PH_COL) && char_class.is_letter) begin
               col_acc_in = col_added;
            end else if (char_class.is_space) begin
               phase_in = PH_SPACE;
            end else if (char_class.is_plus) begin
               phase_in = PH_SIGNED;
            end else if (char_class.is_minus) begin
               row_neg_in = 1'b1;
               phase_in   = PH_SIGNED;
            end else if (char_class.is_digit) begin
               row_acc_in  = row_added;
               overflow_in = overflow_ff || row_over;
               phase_in    = PH_DIGITS;
            end else begin
               error_in = ST_NO_DIGITS;
               phase_in = PH_ERROR;
            end
         end
         PH_SIGNED: begin
            if (char_class.is_digit) begin
               row_acc_in  = row_added;
               overflow_in = overflow_ff || row_over;
               phase_in    = PH_DIGITS;
            end else begin
               error_in = ST_NO_DIGITS;
               phase_in = PH_ERROR;
            end
         end
         PH_DIGITS: begin
            if (char_class.is_digit) begin
               row_acc_in  = row_added;
               overflow_in = overflow_ff || row_over;
            end else begin
               error_in = range_now ? ST_RANGE : ST_TRAILING;
               phase_in = PH_ERROR;
            end
         end
         PH_ERROR: begin
         end
         default: begin
         end
      endcase
   end

   // Final decode of the reference once its last character is consumed.
   assign range_fin = overflow_in ||
                      (!row_neg_in && (row_acc_in > ROW_LIMIT - ROW_ACC_W'(1)));

   always_comb begin
      result.status    = ST_NO_COL;
      result.row_index = '0;
      result.col_index = '0;
      unique case (phase_in)
         PH_COL: begin
            result.status = ST_NO_ROW;
         end
         PH_SPACE, PH_SIGNED: begin
            result.status = ST_NO_DIGITS;
         end
         PH_DIGITS: begin
            if (range_fin) begin
               result.status = ST_RANGE;
            end else if (row_neg_in || (row_acc_in == '0)) begin
               result.status = ST_BELOW_ONE;
            end else if ((col_acc_in > COL_LIMIT) || (col_acc_in == '0)) begin
               result.status = ST_RANGE;
            end else begin
               result.status    = ST_OK;
               result.row_index = ROW_BITS'(row_acc_in - ROW_ACC_W'(1));
               result.col_index = COL_BITS'(col_acc_in - COL_ACC_W'(1));
            end
         end
         PH_ERROR: begin
            result.status = error_in;
         end
         default: begin
            result.status = ST_NO_COL;
         end
      endcase
   end

   // State registers; a finished reference returns everything to its start.
   always_ff @(posedge clock) begin
      if (reset || (step && last)) begin
         phase_ff    <= PH_START;
         col_acc_ff  <= '0;
         row_acc_ff  <= '0;
         row_neg_ff  <= 1'b0;
         overflow_ff <= 1'b0;
         error_ff    <= ST_OK;
      end else if (step) begin
         phase_ff    <= phase_in;
         col_acc_ff  <= col_acc_in;
         row_acc_ff  <= row_acc_in;
         row_neg_ff  <= row_neg_in;
         overflow_ff <= overflow_in;
         error_ff    <= error_in;
      end
   end

endmodule

`default_nettype wire

>>> hw/rtl/a1_cell_reference_parser.sv
// Top level of the A1 cell reference parser: input register, parser and result register.
//
// Requests arrive on the req channel, one character per request, with last
// marking the final character of a reference such as "B12". Each reference
// produces exactly one result on the rsp channel: a status code, the
// zero-based row and the zero-based column (both zero unless status is ok).
// Requests without last produce no result.
//
// A request is accepted whenever req.valid and req.ready are high at a clock
// edge; one request can be taken in every cycle unless a finishing
// character waits for room in the result register. The last character of
// a reference sits in the input register, and the parser then writes its
// result to the result register, which drives rsp. The rate is set by the
// accumulator update in the parser stage.
//
// When the receiver holds rsp.ready low, the result waits in the output
// register; characters that do not end a reference still drain, and the
// input stage stalls only when a second result would be due.
//
// Synchronous reset clears all valid flags and returns the parser to the
// start of a reference.
`default_nettype none

module a1_cell_reference_parser import a1p_pkg::*; (
   input  wire logic  clock,
   input  wire logic  reset,
   a1p_req_if.sink    req,
   a1p_rsp_if.source  rsp
);

   logic              in_valid_ff;
   logic [CHAR_W-1:0] in_char_ff;
   logic              in_last_ff;
   logic              out_valid_ff;
   result_type        out_data_ff;

   logic              out_free;
   logic              step;
   char_class_type    char_class;
   result_type        result;

   // Stage handshake: a finishing character needs room in the result register.
   assign out_free  = !out_valid_ff || rsp.ready;
   assign step      = in_valid_ff && (!in_last_ff || out_free);
   assign req.ready = !in_valid_ff || step;

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req.ready) begin
         in_valid_ff <= req.valid;
      end
      if (req.ready && req.valid) begin
         in_char_ff <= req.character;
         in_last_ff <= req.last;
      end
   end

   a1p_char_class u_char_class (
      .character  (in_char_ff),
      .char_class (char_class)
   );

   a1p_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .step       (step),
      .last       (in_last_ff),
      .char_class (char_class),
      .result     (result)
   );

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (step && in_last_ff) begin
         out_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         out_valid_ff <= 1'b0;
      end
      if (step && in_last_ff) begin
         out_data_ff <= result;
      end
   end

   assign rsp.valid     = out_valid_ff;
   assign rsp.status    = STATUS_W'(out_data_ff.status);
   assign rsp.row_index = out_data_ff.row_index;
   assign rsp.col_index = out_data_ff.col_index;

endmodule

`default_nettype wire
